### rtl/core/cesd_pkg.sv
package cesd_pkg;

    localparam int IdW        = 11;
    localparam int PayloadW   = 64;
    localparam int TimeW      = 32;
    localparam int FuelW      = 15;
    localparam int RateW      = 16;
    localparam int KindW      = 3;
    localparam int AvgDepthDefault = 20;
    localparam int NumRegs    = 5;
    localparam int AddrW      = 5;

    localparam logic [IdW-1:0] SpeedIdReset   = 11'h280;
    localparam logic [IdW-1:0] Engine2IdReset = 11'h288;
    localparam logic [IdW-1:0] IntakeIdReset  = 11'h380;
    localparam logic [IdW-1:0] LampIdReset    = 11'h480;
    localparam logic [IdW-1:0] BoostIdReset   = 11'h588;

    localparam logic [AddrW-1:0] AddrSpeed   = 5'd0;
    localparam logic [AddrW-1:0] AddrEngine2 = 5'd4;
    localparam logic [AddrW-1:0] AddrIntake  = 5'd8;
    localparam logic [AddrW-1:0] AddrLamp    = 5'd12;
    localparam logic [AddrW-1:0] AddrBoost   = 5'd16;

    // multiplier for used*360, 9 bits
    localparam logic [8:0] RateScale = 9'd360;

    // 14.5037738 * 2^32, rounded down
    localparam logic [35:0] BoostMul  = 36'd62293234139;
    localparam logic [12:0] BoostBias = 13'd1470;

    typedef enum logic [KindW-1:0] {
        K_SPEED   = 3'd0,
        K_ENGINE2 = 3'd1,
        K_INTAKE  = 3'd2,
        K_LAMP    = 3'd3,
        K_BOOST   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_AVG,
        S_MEAN,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture accepted frame, update held values
        logic div_start;  // seed the divider
        logic div_step;   // one quotient bit
        logic avg_start;  // apply sample, update the running sum
        logic avg_done;   // latch average
        logic out_load;   // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;   // lamp frame with a usable sample
        logic div_last;
    } t_sts;

    function automatic logic signed [8:0] temp_of(input logic [7:0] b);
        logic signed [10:0] num;
        logic [10:0] mag;
        logic [8:0] q;
        num = $signed({1'b0, b, 2'b00} - {3'b000, b}) - 11'sd192;
        if (num >= 0) begin
            q = num[10:2];
            return $signed(q);
        end
        mag = 11'(-num);
        q = mag[10:2];
        return $signed(9'(-$signed({1'b0, q[7:0]})));
    endfunction

    // b*14.5037738 - 1470 truncated toward zero; the product is never whole
    // for b > 0, so below zero round the floor up by one
    function automatic logic signed [12:0] boost_of(input logic [7:0] b);
        logic [43:0] prod;
        logic [12:0] whole;
        prod  = 44'(b) * 44'(BoostMul);
        whole = {1'b0, prod[43:32]};
        if (b == 8'd0) return $signed(13'd0 - BoostBias);
        if (whole >= BoostBias) return $signed(whole - BoostBias);
        return $signed(whole + 13'd1 - BoostBias);
    endfunction

endpackage

### rtl/core/cesd_ctrl.sv
module cesd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_free,
    input  cesd_pkg::t_sts   i_sts,
    output logic             o_busy,
    output cesd_pkg::t_cmd   o_cmd
);
    import cesd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // decide between direct result and fuel sample path
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                o_cmd.avg_start = 1'b1;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.avg_done = 1'b1;
                n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/core/cesd_dp.sv
module cesd_dp #(
    parameter int AVG_DEPTH = cesd_pkg::AvgDepthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cesd_pkg::t_cmd                i_cmd,
    output cesd_pkg::t_sts                o_sts,
    input  logic [cesd_pkg::IdW-1:0]      i_msg_id,
    input  logic [cesd_pkg::PayloadW-1:0] i_payload,
    input  logic [cesd_pkg::TimeW-1:0]    i_time_ms,
    input  logic [cesd_pkg::IdW-1:0]      i_reg_id [cesd_pkg::NumRegs],
    output logic [2:0]                    o_kind,
    output logic [13:0]                   o_rpm,
    output logic signed [8:0]             o_coolant,
    output logic signed [8:0]             o_intake,
    output logic [11:0]                   o_idle,
    output logic [4:0]                    o_lamps,
    output logic [15:0]                   o_avg,
    output logic signed [12:0]            o_boost,
    output logic                          o_match
);
    import cesd_pkg::*;

    localparam int SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SumW  = RateW + $clog2(AVG_DEPTH + 1);
    localparam int NumW  = FuelW + 9;
    localparam int DivCntW = $clog2(NumW);
    // sum / AVG_DEPTH as a multiply by a rounded-up reciprocal, exact for SumW-bit sums
    localparam int AvgSh = SumW + $clog2(AVG_DEPTH);
    localparam logic [SumW:0] AvgMul =
        (SumW+1)'(((64'd1 << AvgSh) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    logic [RateW-1:0] r_store [AVG_DEPTH];
    logic [SlotW-1:0] r_slot;
    logic [SumW-1:0]  r_sum;
    logic [FuelW-1:0] r_prev_cnt;
    logic [TimeW-1:0] r_prev_t;
    logic             r_have;
    logic [13:0]      r_rpm;
    logic [7:0]       r_cool, r_intk;
    logic [11:0]      r_idle;
    logic [4:0]       r_lamps;
    logic signed [12:0] r_boost;
    logic [15:0]      r_avg;
    logic [2:0]       r_kind;
    logic             r_need;

    logic [NumW-1:0]  r_num;
    logic [TimeW-1:0] r_den;
    logic [TimeW:0]   r_rem;
    logic [NumW-1:0]  r_quo;
    logic [DivCntW-1:0] r_cnt;
    logic [SumW-1:0]  r_asum;
    logic [RateW-1:0] r_old;

    logic [2:0]  kind;
    logic        match;
    logic [7:0]  b1;
    logic [FuelW-1:0] cnt;
    logic [TimeW-1:0] elapsed;
    logic [TimeW:0]   rem_sh;
    logic [RateW-1:0] sample;
    logic [SumW-1:0]  new_sum;
    logic [2*SumW:0]  avg_prod;

    always_comb begin
        kind  = K_SPEED;
        match = 1'b0;
        for (int k = NumRegs - 1; k >= 0; k--) begin
            if (i_reg_id[k] == i_msg_id) begin
                kind  = 3'(k);
                match = 1'b1;
            end
        end
    end
    assign o_match = match;

    assign b1 = i_payload[15:8];
    assign cnt = {i_payload[30:24], i_payload[23:16]};
    assign elapsed = i_time_ms - r_prev_t;

    assign rem_sh   = {r_rem[TimeW-1:0], r_num[NumW-1]};
    assign sample   = (|r_quo[NumW-1:RateW]) ? '1 : r_quo[RateW-1:0];
    assign new_sum  = r_sum - SumW'(r_old) + SumW'(sample);
    assign avg_prod = (2*SumW+1)'(r_asum) * (2*SumW+1)'(AvgMul);

    assign o_sts.need_div = r_need;
    assign o_sts.div_last = (r_cnt == DivCntW'(NumW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_sum      <= '0;
            r_prev_cnt <= '0;
            r_prev_t   <= '0;
            r_have     <= 1'b0;
            r_rpm      <= '0;
            r_cool     <= '0;
            r_intk     <= '0;
            r_idle     <= '0;
            r_lamps    <= '1;
            r_boost    <= '0;
            r_avg      <= '0;
            r_need     <= 1'b0;
            for (int i = 0; i < AVG_DEPTH; i++) r_store[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_kind <= kind;
                r_need <= (kind == K_LAMP) && r_have && (elapsed != '0);
                case (kind)
                    K_SPEED:   r_rpm <= i_payload[31:18];
                    K_ENGINE2: begin
                        r_cool <= b1;
                        r_idle <= 12'({i_payload[47:40], 3'b000}) +
                                  12'({i_payload[47:40], 1'b0});
                    end
                    K_INTAKE:  r_intk <= b1;
                    K_LAMP: begin
                        r_lamps <= {i_payload[50], b1[7], b1[2:0]};
                        r_num   <= NumW'(FuelW'(cnt - r_prev_cnt)) * NumW'(RateScale);
                        r_den   <= elapsed;
                        r_prev_cnt <= cnt;
                        r_prev_t   <= i_time_ms;
                        r_have     <= 1'b1;
                    end
                    default:   r_boost <= boost_of(i_payload[39:32]);
                endcase
            end
            if (i_cmd.div_start) begin
                r_need <= 1'b0;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_old  <= r_store[r_slot];
            end
            if (i_cmd.div_step) begin
                // restoring division, one quotient bit per cycle
                r_num <= {r_num[NumW-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_quo <= {r_quo[NumW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[NumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.avg_start) begin
                r_store[r_slot] <= sample;
                r_sum  <= new_sum;
                r_asum <= new_sum;
                r_slot <= (r_slot == SlotW'(AVG_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.avg_done) begin
                r_avg <= 16'(avg_prod >> AvgSh);
            end
        end
    end

    assign o_kind    = r_kind;
    assign o_rpm     = r_rpm;
    assign o_coolant = temp_of(r_cool);
    assign o_intake  = temp_of(r_intk);
    assign o_idle    = r_idle;
    assign o_lamps   = r_lamps;
    assign o_avg     = r_avg;
    assign o_boost   = r_boost;

endmodule

### rtl/core/can_engine_signal_decoder_unit.sv
// Channel   Dir  tdata / tuser contents
// s_axis    in   tdata: msg_id[10:0], payload[74:11], time_ms[106:75]
// m_axis    out  tdata: frame_type, engine_rpm, coolant_temp, intake_temp,
//                       idle_speed, lamps, fuel_rate_avg, boost_psi
// apb       cfg  five 11-bit identifier registers at 0x00..0x10
//
// A matched frame without a fuel sample is captured on acceptance, and S_OUT
// loads its result once the output is free; unmatched frames are dropped.
// A lamp frame with a sample first runs a restoring divide for used*360/elapsed
// (S_DIV) and the average steps S_AVG, S_MEAN. One frame at a time.
// Synchronous active-low reset; the rate store clears at reset. A stalled result
// holds in the output register; the next matched frame then waits in S_OUT.
module can_engine_signal_decoder_unit #(
    parameter int AVG_DEPTH = cesd_pkg::AvgDepthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // msg_id[10:0], payload[74:11], time_ms[106:75], zero fill
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_type[2:0], engine_rpm[16:3], coolant_temp[25:17], intake_temp[34:26],
    // idle_speed[46:35], lamps[51:47], fuel_rate_avg[67:52], boost_psi[80:68]
    output logic [87:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [cesd_pkg::AddrW-1:0] paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cesd_pkg::*;

    logic [IdW-1:0] r_reg [NumRegs];
    t_cmd cmd;
    t_sts sts;
    logic busy, in_fire, match, r_ovalid;
    logic [87:0] r_odata;
    logic [2:0]  kind;
    logic [13:0] rpm;
    logic signed [8:0] cool, intk;
    logic [11:0] idle;
    logic [4:0]  lamps;
    logic [15:0] avg;
    logic signed [12:0] boost;
    logic        r_drop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg[0] <= SpeedIdReset;
            r_reg[1] <= Engine2IdReset;
            r_reg[2] <= IntakeIdReset;
            r_reg[3] <= LampIdReset;
            r_reg[4] <= BoostIdReset;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                AddrSpeed:   r_reg[0] <= pwdata[IdW-1:0];
                AddrEngine2: r_reg[1] <= pwdata[IdW-1:0];
                AddrIntake:  r_reg[2] <= pwdata[IdW-1:0];
                AddrLamp:    r_reg[3] <= pwdata[IdW-1:0];
                AddrBoost:   r_reg[4] <= pwdata[IdW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            AddrSpeed:   prdata = 32'(r_reg[0]);
            AddrEngine2: prdata = 32'(r_reg[1]);
            AddrIntake:  prdata = 32'(r_reg[2]);
            AddrLamp:    prdata = 32'(r_reg[3]);
            AddrBoost:   prdata = 32'(r_reg[4]);
            default:     prdata = '0;
        endcase
    end

    // unmatched frames are consumed without entering the controller
    assign s_axis_tready = !busy && !r_drop;
    assign in_fire = s_axis_tvalid && s_axis_tready && match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= 1'b0;
        end else begin
            r_drop <= s_axis_tvalid && s_axis_tready && !match;
        end
    end

    cesd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    cesd_dp #(.AVG_DEPTH(AVG_DEPTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_msg_id  (s_axis_tdata[10:0]),
        .i_payload (s_axis_tdata[74:11]),
        .i_time_ms (s_axis_tdata[106:75]),
        .i_reg_id  (r_reg),
        .o_kind    (kind),
        .o_rpm     (rpm),
        .o_coolant (cool),
        .o_intake  (intk),
        .o_idle    (idle),
        .o_lamps   (lamps),
        .o_avg     (avg),
        .o_boost   (boost),
        .o_match   (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_odata <= {7'd0, boost, avg, lamps, idle, intk, cool, rpm, kind};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### test/cesd_checker.sv
module cesd_checker #(
    parameter int AVG_DEPTH = cesd_pkg::AvgDepthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_valid,
    input  logic         s_ready,
    input  logic [111:0] s_data,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [87:0]  m_data,
    input  logic         cfg_wr,
    input  logic [cesd_pkg::AddrW-1:0] cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_frames_seen,
    output int           o_samples_taken
);
    timeunit 1ns;
    timeprecision 1ps;
    import cesd_pkg::*;

    typedef struct packed {
        logic [12:0] boost;
        logic [15:0] avg;
        logic [4:0]  lamps;
        logic [11:0] idle;
        logic [8:0]  intake;
        logic [8:0]  coolant;
        logic [13:0] rpm;
        logic [2:0]  kind;
    } t_dash;

    logic [IdW-1:0] id_reg [NumRegs];
    logic [15:0] rate_hist [AVG_DEPTH];
    int unsigned slot_idx, hist_sum;
    logic [14:0] last_count;
    logic [31:0] last_stamp;
    bit          have_last;
    logic [13:0] rpm_h;
    logic [7:0]  coolant_raw, intake_raw;
    logic [11:0] idle_h;
    logic [4:0]  lamps_h;
    logic [12:0] boost_h;
    logic [15:0] avg_h;
    t_dash       dash_queue[$];

    function automatic logic [8:0] deg_c(input logic [7:0] b);
        int num;
        num = 3 * int'(b) - 192;
        if (num < 0) num = -((-num) / 4);
        else num = num / 4;
        return 9'(num);
    endfunction

    function automatic logic [12:0] psi_centi(input logic [7:0] b);
        longint num;
        num = longint'(b) * 145037738 - 64'sd14700000000;
        if (num < 0) num = -((-num) / 10000000);
        else num = num / 10000000;
        return 13'(num);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic decode_frame(input logic [111:0] d);
        logic [IdW-1:0] id;
        logic [63:0]    p;
        logic [31:0]    now, elapsed, sample;
        logic [14:0]    cnt, used;
        int             kind;
        t_dash          e;
        id = d[10:0];
        p = d[74:11];
        now = d[106:75];
        kind = -1;
        for (int k = NumRegs - 1; k >= 0; k--)
            if (id_reg[k] == id) kind = k;
        if (kind < 0) return;
        case (kind)
            K_SPEED: rpm_h = 14'({p[31:24], p[23:16]} >> 2);
            K_ENGINE2: begin
                coolant_raw = p[15:8];
                idle_h = 12'(p[47:40] * 10);
            end
            K_INTAKE: intake_raw = p[15:8];
            K_LAMP: begin
                lamps_h = {p[50], p[15], p[10:8]};
                cnt = {p[30:24], p[23:16]};
                if (have_last) begin
                    used = cnt - last_count;
                    elapsed = now - last_stamp;
                    if (elapsed != 0) begin
                        sample = (32'(used) * 360) / elapsed;
                        if (sample > 65535) sample = 65535;
                        hist_sum = hist_sum - rate_hist[slot_idx] + sample;
                        rate_hist[slot_idx] = 16'(sample);
                        slot_idx = (slot_idx + 1) % AVG_DEPTH;
                        avg_h = 16'(hist_sum / AVG_DEPTH);
                        o_samples_taken++;
                    end
                end
                last_count = cnt;
                last_stamp = now;
                have_last = 1;
            end
            default: boost_h = psi_centi(p[39:32]);
        endcase
        e.kind = 3'(kind);
        e.rpm = rpm_h;
        e.coolant = deg_c(coolant_raw);
        e.intake = deg_c(intake_raw);
        e.idle = idle_h;
        e.lamps = lamps_h;
        e.avg = avg_h;
        e.boost = boost_h;
        dash_queue.push_back(e);
    endtask

    task automatic compare_dash(input t_dash got);
        t_dash w;
        if (dash_queue.size() == 0) begin
            report("unexpected transaction", got.kind, 0);
            return;
        end
        w = dash_queue.pop_front();
        if (got.kind != w.kind) report("frame_type", got.kind, w.kind);
        if (got.rpm != w.rpm) report("engine_rpm", got.rpm, w.rpm);
        if (got.coolant != w.coolant) report("coolant_temp", got.coolant, w.coolant);
        if (got.intake != w.intake) report("intake_temp", got.intake, w.intake);
        if (got.idle != w.idle) report("idle_speed", got.idle, w.idle);
        if (got.lamps != w.lamps) report("lamps", got.lamps, w.lamps);
        if (got.avg != w.avg) report("fuel_rate_avg", got.avg, w.avg);
        if (got.boost != w.boost) report("boost_psi", got.boost, w.boost);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            id_reg[0] = SpeedIdReset;
            id_reg[1] = Engine2IdReset;
            id_reg[2] = IntakeIdReset;
            id_reg[3] = LampIdReset;
            id_reg[4] = BoostIdReset;
            for (int i = 0; i < AVG_DEPTH; i++) rate_hist[i] = '0;
            slot_idx = 0;
            hist_sum = 0;
            last_count = '0;
            last_stamp = '0;
            have_last = 0;
            rpm_h = '0;
            coolant_raw = '0;
            intake_raw = '0;
            idle_h = '0;
            lamps_h = '1;
            boost_h = '0;
            avg_h = '0;
            dash_queue.delete();
        end else begin
            if (cfg_wr && cfg_addr[1:0] == 2'b00 && cfg_addr[AddrW-1:2] < NumRegs)
                id_reg[cfg_addr[AddrW-1:2]] = cfg_wdata[IdW-1:0];
            if (m_valid && m_ready) compare_dash(t_dash'(m_data[80:0]));
            if (s_valid && s_ready) begin
                decode_frame(s_data);
                o_frames_seen++;
            end
        end
        o_pending = dash_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_frames_seen = 0;
        o_samples_taken = 0;
    end
endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cesd_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         psel, penable, pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count, pending, frames_seen, samples_taken;
    logic [IdW-1:0] ids [NumRegs];
    logic [31:0]  clock_ms;
    logic [14:0]  fuel_ctr;

    can_engine_signal_decoder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cesd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
        .cfg_wr(psel && penable && pwrite && pready), .cfg_addr(paddr),
        .cfg_wdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_frames_seen(frames_seen), .o_samples_taken(samples_taken)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // receiver stall: new random wait per transaction, some stretches without
    initial begin
        int wait_n;
        m_axis_tready = 0;
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_n != 0) begin
                m_axis_tready <= 0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic write_id(input int idx, input logic [IdW-1:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= AddrW'(idx * 4); pwdata <= 32'(v);
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        ids[idx] = v;
    endtask

    // valid stays up after a transaction; drain() lowers it, the next call only when its gap is nonzero
    task automatic send_frame(input logic [IdW-1:0] id, input logic [63:0] p,
                              input logic [31:0] t, input bit gap);
        int idle_n;
        idle_n = gap ? $urandom_range(0, 19) : 0;
        if (idle_n != 0) begin
            s_axis_tvalid <= 0;
            repeat (idle_n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {5'd0, t, p, id};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // lamp frame with a plausible fuel counter advance
    task automatic send_lamp(input bit gap);
        logic [63:0] p;
        p = rand64();
        fuel_ctr = fuel_ctr + 15'($urandom_range(0, 3000));
        clock_ms = clock_ms + ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 2000));
        p[23:16] = fuel_ctr[7:0];
        p[30:24] = fuel_ctr[14:8];
        send_frame(ids[K_LAMP], p, clock_ms, gap);
    endtask

    initial begin
        logic [63:0] p;
        int r, phase_gap;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        ids[0] = SpeedIdReset; ids[1] = Engine2IdReset; ids[2] = IntakeIdReset;
        ids[3] = LampIdReset; ids[4] = BoostIdReset;
        clock_ms = 0;
        fuel_ctr = 0;
        i_rst_n = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: values before any update, extremes, special cases
        send_frame(ids[K_BOOST], '0, 0, 0);
        send_frame(ids[K_SPEED], '1, 1, 1);
        send_frame(ids[K_ENGINE2], '1, 2, 1);
        send_frame(ids[K_INTAKE], '1, 3, 1);
        send_frame(ids[K_BOOST], '1, 4, 1);
        send_frame(ids[K_ENGINE2], 64'h0000_0040_0000_4000, 5, 0);
        send_frame(11'h7ff, '1, 6, 0);
        send_frame(11'h000, '0, 7, 0);
        send_frame(ids[K_LAMP], 64'h0000_0000_7f00_0000, 100, 0);
        send_frame(ids[K_LAMP], 64'h0000_0000_7f00_0000, 100, 0);
        send_frame(ids[K_LAMP], 64'h0000_0000_0005_0000, 101, 0);
        send_frame(ids[K_LAMP], 64'h0000_0000_7fff_0000, 102, 1);
        send_frame(ids[K_LAMP], '1, 32'hffff_ffff, 1);
        send_frame(ids[K_LAMP], '0, 32'h0000_0002, 1);
        send_frame(ids[K_LAMP], 64'h0004_0000_0000_8700, 32'h8000_0000, 1);
        drain();
        // duplicate identifiers: the lowest register wins
        write_id(3, ids[K_SPEED]);
        write_id(4, 11'h000);
        send_frame(ids[K_SPEED], '1, 200, 0);
        send_frame(11'h000, 64'h0000_00ff_0000_0000, 201, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: for (int k = 0; k < NumRegs; k++) write_id(k, 11'(k));
                1: for (int k = 0; k < NumRegs; k++) write_id(k, 11'h7ff - 11'(k));
                default: for (int k = 0; k < NumRegs; k++) write_id(k, 11'($urandom()));
            endcase
            if (ids[K_LAMP] == ids[K_SPEED]) write_id(K_LAMP, ids[K_SPEED] ^ 11'h400);
            phase_gap = (ph % 2 == 0);
            for (int n = 0; n < 230; n++) begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    send_lamp(phase_gap);
                end else if (r < 8) begin
                    send_frame(ids[$urandom_range(0, NumRegs - 1)], rand64(),
                               $urandom(), phase_gap);
                end else begin
                    send_frame(11'($urandom()), rand64(), $urandom(), phase_gap);
                end
            end
            drain();
        end

        $display("frames accepted %0d, fuel samples %0d, six identifier settings",
                 frames_seen, samples_taken);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/cesd_pkg.sv
rtl/core/cesd_ctrl.sv
rtl/core/cesd_dp.sv
rtl/core/can_engine_signal_decoder_unit.sv
test/cesd_checker.sv
test/tb.sv
